// ===== src/ssag_pkg.sv =====
// Shared types and constants of the star sprite alpha generator.
package ssag_pkg;

	localparam int COORD_W   = 10;
	localparam int SIZE_W    = 11;
	localparam int INT_W     = 17;
	localparam int LVL_W     = 8;
	localparam int CFG_W     = 17;
	localparam int IDX_W     = 3;

	localparam int MAX_SIZE_DEF = 1024;

	// pipeline depths
	localparam int SQ_STEPS  = 28;   // root bits of isqrt(sq << 32)
	localparam int DIV_STEPS = 25;   // quotient bits of the cross terms
	localparam int RAD_STEPS = 16;   // fraction bits of dist / size

	localparam logic [16:0] ONE_Q16   = 17'h10000;
	localparam logic [13:0] FIFTH_Q16 = 14'd13107;

	localparam logic [SIZE_W-1:0] SIZE_RST = 11'd256;
	localparam logic [INT_W-1:0]  INT_RST  = 17'h10000;
	localparam logic [LVL_W-1:0]  LVL_RST  = 8'hFF;

	typedef enum logic [IDX_W-1:0] {
		REG_SIZE      = 3'd0,
		REG_INTENSITY = 3'd1,
		REG_RED       = 3'd2,
		REG_GREEN     = 3'd3,
		REG_BLUE      = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} pix_t;

	typedef struct packed {
		logic [LVL_W-1:0] red_out;
		logic [LVL_W-1:0] green_out;
		logic [LVL_W-1:0] blue_out;
		logic [LVL_W-1:0] alpha_out;
	} rgba_t;

endpackage

// ===== src/star_sprite_alpha_generator.sv =====
// Glowing star sprite generator: pixel coordinate in, RGBA pixel out.
//
// Use: present a pixel coordinate on pix with pix_valid; it is taken on a
// transfer (pix_valid and pix_ready high at a rising edge). Each pixel gives
// exactly one RGBA result on rgba, taken on a transfer with rgba_ready.
// Colour bytes come straight from the colour registers; alpha is a radial
// falloff reinforced along the centre row and column, clamped and scaled.
// Configuration goes through cfg_we / cfg_index / cfg_data, one register per
// cycle, and may only be written while no pixel is in flight.
// Throughput: one pixel per cycle. The depth is set by the square root
// (one root bit per stage, 28 stages) followed by the dist / size divider
// (16 stages); the two cross-term dividers run beside the square root.
// Reset: arst_n clears all valid bits and loads the register defaults
// (size 256, intensity 1.0, white).
// Stall: while a result waits and rgba_ready is low, the whole pipeline
// holds and pix_ready is low; nothing is dropped or repeated, and bubbles
// travel through as invalid stages.
module star_sprite_alpha_generator
	import ssag_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             pix_valid,
	output logic             pix_ready,
	input  pix_t             pix,
	output logic             rgba_valid,
	input  logic             rgba_ready,
	output rgba_t            rgba
);

	// configuration registers
	logic [SIZE_W-1:0] size_q;
	logic [INT_W-1:0]  inten_q;
	logic [LVL_W-1:0]  red_q, green_q, blue_q;
	logic [SIZE_W-1:0] s_eff;
	logic [24:0]       num_q;   // floor(3*S*I / 32)

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_RST;
			inten_q <= INT_RST;
			red_q   <= LVL_RST;
			green_q <= LVL_RST;
			blue_q  <= LVL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIZE:      size_q  <= cfg_data[SIZE_W-1:0];
				REG_INTENSITY: inten_q <= cfg_data[INT_W-1:0];
				REG_RED:       red_q   <= cfg_data[LVL_W-1:0];
				REG_GREEN:     green_q <= cfg_data[LVL_W-1:0];
				REG_BLUE:      blue_q  <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	// size clamp
	always_comb begin
		if (32'(size_q) > MAX_SIZE) s_eff = SIZE_W'(MAX_SIZE);
		else                        s_eff = size_q;
	end

	// cross-term numerator, refreshed every cycle from the registers
	logic [12:0] s3;
	logic [29:0] num_full;
	assign s3       = {s_eff, 1'b0} + {2'b00, s_eff};
	assign num_full = s3 * inten_q;
	always_ff @(posedge clk) begin
		num_q <= num_full[29:5];
	end

	// pipeline advance: the output register is empty or being taken
	logic pipe_en;
	assign pipe_en   = !rgba_valid || rgba_ready;
	assign pix_ready = pipe_en;

	// stage 1: capture
	logic               v_s1;
	logic [COORD_W-1:0] px_s1, py_s1;
	// stage 2: half-pixel offsets
	logic               v_s2;
	logic signed [11:0] dx_s2, dy_s2;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			px_s1 <= pix.pixel_x;
			py_s1 <= pix.pixel_y;
			dx_s2 <= {1'b0, px_s1, 1'b0} - {1'b0, s_eff};
			dy_s2 <= {1'b0, py_s1, 1'b0} - {1'b0, s_eff};
		end
	end

	// square root chain, with the two cross-term dividers beside it
	logic              sv   [0:SQ_STEPS];
	logic [23:0]       sqv  [0:SQ_STEPS];
	logic [27:0]       rt   [0:SQ_STEPS];
	logic [29:0]       rm   [0:SQ_STEPS];
	logic [10:0]       adx  [0:SQ_STEPS];
	logic [10:0]       ady  [0:SQ_STEPS];
	logic              zx   [0:SQ_STEPS];
	logic              zy   [0:SQ_STEPS];
	logic [24:0]       qx   [0:SQ_STEPS];
	logic [24:0]       qy   [0:SQ_STEPS];
	logic [10:0]       wx   [0:SQ_STEPS];
	logic [10:0]       wy   [0:SQ_STEPS];

	logic signed [23:0] dxx, dyy;
	logic [23:0]        sq_sum;
	logic [11:0]        adx_w, ady_w;
	assign dxx    = dx_s2 * dx_s2;
	assign dyy    = dy_s2 * dy_s2;
	assign sq_sum = dxx + dyy;
	assign adx_w  = (dx_s2 < 0) ? -dx_s2 : dx_s2;
	assign ady_w  = (dy_s2 < 0) ? -dy_s2 : dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			sv[0] <= 1'b0;
		end else if (pipe_en) begin
			v_s1  <= pix_valid;
			v_s2  <= v_s1;
			sv[0] <= v_s2;
		end
	end

	// stage 3 is element 0 of the chain
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			sqv[0] <= sq_sum;
			rt[0]  <= '0;
			rm[0]  <= '0;
			adx[0] <= adx_w[10:0];
			ady[0] <= ady_w[10:0];
			zx[0]  <= (dx_s2 == 0);
			zy[0]  <= (dy_s2 == 0);
			qx[0]  <= '0;
			qy[0]  <= '0;
			wx[0]  <= '0;
			wy[0]  <= '0;
		end
	end

	genvar k;
	generate
		for (k = 0; k < SQ_STEPS; k++) begin : g_sq
			localparam int PI = SQ_STEPS - 1 - k;
			logic [1:0]  pair;
			logic [31:0] t_rm;
			logic [31:0] trial;
			logic        ge_rm;
			logic [24:0] qx_n, qy_n;
			logic [10:0] wx_n, wy_n;

			if (PI >= 16) begin : g_pair
				assign pair = sqv[k][2*(PI-16)+1 -: 2];
			end else begin : g_zero
				assign pair = 2'b00;
			end

			assign t_rm  = {rm[k], pair};
			assign trial = {2'b00, rt[k], 2'b01};
			assign ge_rm = t_rm >= trial;

			if (k < DIV_STEPS) begin : g_div
				logic [11:0] tx, ty;
				logic        gx, gy;
				assign tx   = {wx[k], num_q[DIV_STEPS-1-k]};
				assign ty   = {wy[k], num_q[DIV_STEPS-1-k]};
				assign gx   = tx >= {1'b0, adx[k]};
				assign gy   = ty >= {1'b0, ady[k]};
				assign wx_n = gx ? 11'(tx - {1'b0, adx[k]}) : tx[10:0];
				assign wy_n = gy ? 11'(ty - {1'b0, ady[k]}) : ty[10:0];
				assign qx_n = {qx[k][23:0], gx};
				assign qy_n = {qy[k][23:0], gy};
			end else begin : g_hold
				assign wx_n = wx[k];
				assign wy_n = wy[k];
				assign qx_n = qx[k];
				assign qy_n = qy[k];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sv[k+1] <= 1'b0;
				end else if (pipe_en) begin
					sv[k+1] <= sv[k];
				end
			end

			always_ff @(posedge clk) begin
				if (pipe_en) begin
					sqv[k+1] <= sqv[k];
					rm[k+1]  <= ge_rm ? 30'(t_rm - trial) : t_rm[29:0];
					rt[k+1]  <= {rt[k][26:0], ge_rm};
					adx[k+1] <= adx[k];
					ady[k+1] <= ady[k];
					zx[k+1]  <= zx[k];
					zy[k+1]  <= zy[k];
					qx[k+1]  <= qx_n;
					qy[k+1]  <= qy_n;
					wx[k+1]  <= wx_n;
					wy[k+1]  <= wy_n;
				end
			end
		end
	endgenerate

	// cross terms; centre row/column gives c = S/2 in Q16
	logic [25:0] tx_f, ty_f;
	assign tx_f = zx[SQ_STEPS] ? {s_eff, 15'b0} : {1'b0, qx[SQ_STEPS]};
	assign ty_f = zy[SQ_STEPS] ? {s_eff, 15'b0} : {1'b0, qy[SQ_STEPS]};

	// dist / size divider; element 0 also registers the cross-term product
	logic        rv  [0:RAD_STEPS];
	logic [27:0] rrt [0:RAD_STEPS];
	logic [11:0] rw  [0:RAD_STEPS];
	logic [15:0] rq  [0:RAD_STEPS];
	logic        rz  [0:RAD_STEPS];
	logic [51:0] pr  [0:RAD_STEPS];
	logic [51:0] txy;
	assign txy = tx_f * ty_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv[0] <= 1'b0;
		end else if (pipe_en) begin
			rv[0] <= sv[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rrt[0] <= rt[SQ_STEPS];
			rw[0]  <= rt[SQ_STEPS][27:16];
			// quotient of 1.0 or more: radial term not positive (also zero size)
			rz[0]  <= rt[SQ_STEPS][27:16] >= {1'b0, s_eff};
			rq[0]  <= '0;
			pr[0]  <= txy;
		end
	end

	genvar j;
	generate
		for (j = 0; j < RAD_STEPS; j++) begin : g_rad
			logic [12:0] t_rw;
			logic        ge_rw;
			assign t_rw  = {rw[j], rrt[j][RAD_STEPS-1-j]};
			assign ge_rw = t_rw >= {2'b00, s_eff};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rv[j+1] <= 1'b0;
				end else if (pipe_en) begin
					rv[j+1] <= rv[j];
				end
			end

			always_ff @(posedge clk) begin
				if (pipe_en) begin
					rrt[j+1] <= rrt[j];
					rw[j+1]  <= ge_rw ? 12'(t_rw - {2'b00, s_eff}) : t_rw[11:0];
					rq[j+1]  <= {rq[j][14:0], ge_rw};
					rz[j+1]  <= rz[j];
					pr[j+1]  <= pr[j];
				end
			end
		end
	endgenerate

	// tail: radial, clamp of the cross product, the two alpha parts
	logic        v_u1, v_u2;
	logic        zr_u1, zr_u2;
	logic [16:0] r_u1;
	logic [32:0] p_u1;
	logic [33:0] ir_u1;
	logic [15:0] a1_u2;
	logic [33:0] a2_u2;

	logic [16:0] r_w;
	logic [33:0] ir_w;
	logic [32:0] p_w;
	logic [49:0] rp_w;
	logic [31:0] a1p_w;
	assign r_w   = ONE_Q16 - {1'b0, rq[RAD_STEPS]};
	assign ir_w  = inten_q * r_w;
	assign p_w   = (pr[RAD_STEPS][51:16] > 36'h1_0000_0000) ? 33'h1_0000_0000
	             : pr[RAD_STEPS][48:16];
	assign rp_w  = r_u1 * p_u1;
	assign a1p_w = ir_u1[33:16] * FIFTH_Q16;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			r_u1  <= r_w;
			p_u1  <= p_w;
			ir_u1 <= ir_w;
			zr_u1 <= rz[RAD_STEPS];
			a1_u2 <= a1p_w[31:16];
			a2_u2 <= rp_w[49:16];
			zr_u2 <= zr_u1;
		end
	end

	// output stage: saturate the sum to 1.0, scale by 255
	logic [34:0] sum_w;
	logic [16:0] sat_w;
	logic [24:0] sc_w;
	logic [7:0]  alpha_w;
	assign sum_w   = {19'b0, a1_u2} + {1'b0, a2_u2};
	assign sat_w   = (sum_w > {18'b0, ONE_Q16}) ? ONE_Q16 : sum_w[16:0];
	assign sc_w    = {sat_w, 8'b0} - {8'b0, sat_w};
	assign alpha_w = zr_u2 ? 8'h00 : sc_w[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_u1       <= 1'b0;
			v_u2       <= 1'b0;
			rgba_valid <= 1'b0;
		end else if (pipe_en) begin
			v_u1       <= rv[RAD_STEPS];
			v_u2       <= v_u1;
			rgba_valid <= v_u2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rgba.red_out   <= red_q;
			rgba.green_out <= green_q;
			rgba.blue_out  <= blue_q;
			rgba.alpha_out <= alpha_w;
		end
	end

	// checks
	logic [57:0] root_a, root_sq_a, root1_sq_a, rad_a;
	logic [31:0] div_a;
	assign root_a     = {30'b0, rt[SQ_STEPS]};
	assign root_sq_a  = root_a * root_a;
	assign root1_sq_a = (root_a + 58'd1) * (root_a + 58'd1);
	assign rad_a      = {2'b00, sqv[SQ_STEPS], 32'b0};
	assign div_a      = 32'(rq[RAD_STEPS]) * 32'(s_eff) + 32'(rw[RAD_STEPS]);

	a_sqrt_floor: assert property (@(posedge clk) disable iff (!arst_n)
		sv[SQ_STEPS] |-> (root_sq_a <= rad_a) && (root1_sq_a > rad_a))
		else $error("square root stage off floor");

	a_rad_div: assert property (@(posedge clk) disable iff (!arst_n)
		rv[RAD_STEPS] && !rz[RAD_STEPS] |-> div_a == 32'(rrt[RAD_STEPS]))
		else $error("dist / size quotient inconsistent");

	a_radial_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_u1 && !zr_u1 |-> (r_u1 != 17'd0) && (r_u1 <= ONE_Q16))
		else $error("radial term out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(sv[SQ_STEPS/2]) && $stable(rv[RAD_STEPS/2]) && $stable(v_u2))
		else $error("pipeline moved during stall");

endmodule
